// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- hdl/blil_pkg.sv -----
// ----------------------------------------------------------------------------
// blil_pkg
// Constants, codes and types shared by the bounded identifier list.
// ----------------------------------------------------------------------------
package blil_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 32;
  localparam int OUT_CNT_W = 7;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic cmp;       // capture the match flag for the incoming request
    logic occupied;  // cell lies below the fill count
    logic load;      // write the appended identifier
    logic shift;     // take the neighbor's entry
  } cell_ctl_t;

endpackage

// ----- hdl/bounded_id_list_insert_remove.sv -----
// ----------------------------------------------------------------------------
// bounded_id_list_insert_remove
// Ordered list of up to CAPACITY identifiers with append, remove and clear.
// ----------------------------------------------------------------------------
// For each request, at the accepting edge every cell compares its
// entry against in_signal_id; in the following cycle the prefix OR network
// picks the first match, the row of cells shifts one place toward the head
// behind it (or the tail cell loads an appended id), and the result is
// registered, to be strobed on out_valid for one cycle in the cycle after.
// busy is high for the execute cycle only, so a new request can be taken
// at the earliest at the same edge that takes the previous result. The
// result cannot be held off, so the receiver must take out_entry_count and
// out_status when out_valid is high.
module bounded_id_list_insert_remove (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_op,
  input  logic signed [blil_pkg::ID_W-1:0]   in_signal_id,
  output logic                               out_valid,
  output logic [blil_pkg::OUT_CNT_W-1:0]     out_entry_count,
  output logic [1:0]                         out_status
);

  localparam int N = blil_pkg::CAPACITY;
  localparam int W = blil_pkg::CNT_W;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                            state_r;
  logic [1:0]                        op_r;
  logic [blil_pkg::ID_W-1:0]         id_r;
  logic [W-1:0]                      cnt_r;
  logic [W-1:0]                      cnt_nxt;
  logic                              out_valid_r;
  logic [blil_pkg::OUT_CNT_W-1:0]    out_cnt_r;
  logic [1:0]                        out_status_r;
  logic [1:0]                        status_nxt;

  logic                              accept;
  logic                              full;
  logic                              found;
  logic                              do_load;
  logic                              do_shift;

  logic [N-1:0]                      match;
  logic [N-1:0]                      pfx;
  logic [blil_pkg::ID_W-1:0]         entry [N];
  blil_pkg::cell_ctl_t               ctl   [N];

  assign accept = start && (state_r == S_IDLE);
  assign full   = (cnt_r == W'(N));
  assign found  = pfx[N-1];

  always_comb begin
    cnt_nxt    = cnt_r;
    status_nxt = blil_pkg::ST_DONE;
    do_load    = 1'b0;
    do_shift   = 1'b0;
    unique case (op_r)
      blil_pkg::OP_APPEND: begin
        if (full) begin
          status_nxt = blil_pkg::ST_FULL;
        end else begin
          do_load = 1'b1;
          cnt_nxt = cnt_r + W'(1);
        end
      end
      blil_pkg::OP_REMOVE: begin
        if (found) begin
          do_shift = 1'b1;
          cnt_nxt  = cnt_r - W'(1);
        end else begin
          status_nxt = blil_pkg::ST_NOT_FOUND;
        end
      end
      blil_pkg::OP_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        // unused code: leave the list alone
      end
    endcase
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [blil_pkg::ID_W-1:0] nbr;

    if (i < N - 1) begin : g_mid
      assign nbr = entry[i+1];
    end else begin : g_tail
      assign nbr = entry[i];
    end

    always_comb begin
      ctl[i].cmp      = accept;
      ctl[i].occupied = (W'(i) < cnt_r);
      ctl[i].load     = (state_r == S_EXEC) && do_load && (cnt_r == W'(i));
      ctl[i].shift    = (state_r == S_EXEC) && do_shift && pfx[i];
    end

    blil_cell u_cell (
      .clk      (clk),
      .ctl      (ctl[i]),
      .cmp_id   (in_signal_id),
      .load_id  (id_r),
      .nbr_data (nbr),
      .entry    (entry[i]),
      .match    (match[i])
    );
  end

  blil_prefix u_prefix (
    .match (match),
    .pfx   (pfx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r      <= S_IDLE;
          cnt_r        <= cnt_nxt;
          out_valid_r  <= 1'b1;
          out_cnt_r    <= blil_pkg::OUT_CNT_W'(cnt_nxt);
          out_status_r <= status_nxt;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
    // hold the request for the execute cycle
    if (accept) begin
      op_r <= in_op;
      id_r <= in_signal_id;
    end
  end

  assign busy            = (state_r == S_EXEC);
  assign out_valid       = out_valid_r;
  assign out_entry_count = out_cnt_r;
  assign out_status      = out_status_r;

endmodule

// ----- hdl/blil_cell.sv -----
// ----------------------------------------------------------------------------
// blil_cell
// One list slot: holds an entry, flags a match and shifts from its neighbor.
// ----------------------------------------------------------------------------
module blil_cell (
  input  logic                      clk,
  input  blil_pkg::cell_ctl_t       ctl,
  input  logic [blil_pkg::ID_W-1:0] cmp_id,
  input  logic [blil_pkg::ID_W-1:0] load_id,
  input  logic [blil_pkg::ID_W-1:0] nbr_data,
  output logic [blil_pkg::ID_W-1:0] entry,
  output logic                      match
);

  logic [blil_pkg::ID_W-1:0] entry_r;
  logic                      match_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry_r <= load_id;
    end else if (ctl.shift) begin
      entry_r <= nbr_data;
    end
    if (ctl.cmp) begin
      match_r <= ctl.occupied && (entry_r == cmp_id);
    end
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

// ----- hdl/blil_prefix.sv -----
// ----------------------------------------------------------------------------
// blil_prefix
// Log-depth prefix OR over the match flags: bit i is set when any cell at or
// ahead of position i matched.
// ----------------------------------------------------------------------------
module blil_prefix (
  input  logic [blil_pkg::CAPACITY-1:0] match,
  output logic [blil_pkg::CAPACITY-1:0] pfx
);

  always_comb begin
    logic [blil_pkg::CAPACITY-1:0] v;
    v = match;
    for (int s = 1; s < blil_pkg::CAPACITY; s = s * 2) begin
      v = v | (v << s);
    end
    pfx = v;
  end

endmodule

// ----- hdl/blil_checker.sv -----
// ----------------------------------------------------------------------------
// blil_checker
// Port-level checks on request/result timing and status consistency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module blil_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic [1:0]                     in_op,
  input logic                           out_valid,
  input logic [blil_pkg::OUT_CNT_W-1:0] out_entry_count,
  input logic [1:0]                     out_status
);

  // every accepted request yields a result after its execute cycle
  `ASSERT_NXT(a_req_gives_result, clk, rst_n, $past(start && !busy), out_valid)

  // no result without an earlier accepted request
  `ASSERT_IMP(a_no_spurious_result, clk, rst_n, out_valid, $past(start && !busy, 2))

  // a dropped append only happens on a full list
  `ASSERT_IMP(a_full_count, clk, rst_n,
    out_valid && (out_status == blil_pkg::ST_FULL),
    out_entry_count == blil_pkg::OUT_CNT_W'(blil_pkg::CAPACITY))

  // clear always reports an empty list and success
  `ASSERT_IMP(a_clear_empties, clk, rst_n,
    out_valid && $past(start && !busy && (in_op == blil_pkg::OP_CLEAR), 2),
    (out_entry_count == '0) && (out_status == blil_pkg::ST_DONE))

endmodule

bind bounded_id_list_insert_remove blil_checker u_blil_checker (.*);

// ----- tb/bounded_id_list_insert_remove_test.sv -----
// ----------------------------------------------------------------------------
// bounded_id_list_insert_remove_test
// Self-checking bench for the bounded identifier list. A scoreboard keeps its
// own ordered copy of the list and predicts count and status for every
// request. Directed requests come first, then random fill, drain and mixed
// segments with random sender gaps.
// ----------------------------------------------------------------------------
module bounded_id_list_insert_remove_test;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1125;
  localparam int IDLE_LIMIT   = 200;

  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  typedef struct {
    logic [blil_pkg::OUT_CNT_W-1:0] count;
    logic [1:0]                     status;
  } list_result_t;

  class id_list_scoreboard;
    logic [blil_pkg::ID_W-1:0] ids[$];
    list_result_t              awaited[$];
    int                        errors = 0;

    function void note_request(logic [1:0] op, logic [blil_pkg::ID_W-1:0] id);
      list_result_t r;
      int pos;
      r.status = blil_pkg::ST_DONE;
      pos = -1;
      case (op)
        blil_pkg::OP_APPEND: begin
          if (ids.size() >= blil_pkg::CAPACITY) r.status = blil_pkg::ST_FULL;
          else ids = {ids, id};
        end
        blil_pkg::OP_REMOVE: begin
          for (int i = 0; i < ids.size(); i++)
            if (pos < 0 && ids[i] === id) pos = i;
          if (pos < 0) r.status = blil_pkg::ST_NOT_FOUND;
          else ids.delete(pos);
        end
        blil_pkg::OP_CLEAR: ids.delete();
        default: ;
      endcase
      r.count = blil_pkg::OUT_CNT_W'(ids.size());
      awaited = {awaited, r};
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(logic [blil_pkg::OUT_CNT_W-1:0] count, logic [1:0] status);
      list_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch("unrequested result, count", count, 0);
        return;
      end
      want = awaited.pop_front();
      if (count !== want.count) report_mismatch("entry_count", count, want.count);
      if (status !== want.status) report_mismatch("status", status, want.status);
    endtask
  endclass

  logic                                 clk;
  logic                                 rst_n;
  logic                                 start;
  logic                                 busy;
  logic [1:0]                           in_op;
  logic signed [blil_pkg::ID_W-1:0]     in_signal_id;
  logic                                 out_valid;
  logic [blil_pkg::OUT_CNT_W-1:0]       out_entry_count;
  logic [1:0]                           out_status;

  id_list_scoreboard sb = new;
  int idle_cycles = 0;
  logic [blil_pkg::ID_W-1:0] id_pool[8] = '{32'h0000_0000, 32'h0000_0001,
                                            32'hFFFF_FFFF, 32'h8000_0000,
                                            32'h7FFF_FFFF, 32'h1234_5678,
                                            32'hA5A5_A5A5, 32'h5A5A_5A5A};

  bounded_id_list_insert_remove u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_signal_id    (in_signal_id),
    .out_valid       (out_valid),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_entry_count, out_status);
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // hold the request until the block takes it, then record it
  task automatic send_request(input logic [1:0] op, input logic [blil_pkg::ID_W-1:0] id);
    start        <= 1'b1;
    in_op        <= op;
    in_signal_id <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(op, id);
  endtask

  task automatic hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // sample at the falling edge so the count is settled for this cycle
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  function automatic logic [blil_pkg::ID_W-1:0] pick_id();
    if ($urandom_range(99) < 55) return id_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  function automatic logic [blil_pkg::ID_W-1:0] pick_remove_id();
    if (sb.ids.size() != 0 && $urandom_range(99) < 75)
      return sb.ids[$urandom_range(sb.ids.size() - 1)];
    return pick_id();
  endfunction

  task automatic send_random(input int mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      MODE_FILL: begin
        if (r < 85) send_request(blil_pkg::OP_APPEND, pick_id());
        else if (r < 95) send_request(blil_pkg::OP_REMOVE, pick_remove_id());
        else if (r < 97) send_request(blil_pkg::OP_CLEAR, $urandom);
        else send_request(OP_UNUSED, $urandom);
      end
      MODE_DRAIN: begin
        if (r < 85) send_request(blil_pkg::OP_REMOVE, pick_remove_id());
        else if (r < 96) send_request(blil_pkg::OP_APPEND, pick_id());
        else if (r < 98) send_request(blil_pkg::OP_CLEAR, $urandom);
        else send_request(OP_UNUSED, $urandom);
      end
      default: begin
        if (r < 45) send_request(blil_pkg::OP_APPEND, pick_id());
        else if (r < 90) send_request(blil_pkg::OP_REMOVE, pick_remove_id());
        else if (r < 95) send_request(blil_pkg::OP_CLEAR, $urandom);
        else send_request(OP_UNUSED, $urandom);
      end
    endcase
  endtask

  initial begin
    int mode;
    int seg_left;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_op        <= blil_pkg::OP_APPEND;
    in_signal_id <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: remove misses, clear and the unused code leave it empty
    send_request(blil_pkg::OP_REMOVE, 32'h0000_0005);
    send_request(blil_pkg::OP_CLEAR,  32'h0000_0000);
    send_request(OP_UNUSED,           32'h0000_0000);
    // extremes, with a duplicate behind them
    send_request(blil_pkg::OP_APPEND, 32'h8000_0000);
    send_request(blil_pkg::OP_APPEND, 32'h7FFF_FFFF);
    send_request(blil_pkg::OP_APPEND, 32'h0000_0000);
    send_request(blil_pkg::OP_APPEND, 32'hFFFF_FFFF);
    send_request(blil_pkg::OP_APPEND, 32'h7FFF_FFFF);
    send_request(blil_pkg::OP_REMOVE, 32'h7FFF_FFFF);
    send_request(blil_pkg::OP_REMOVE, 32'h7FFF_FFFE);
    send_request(OP_UNUSED,           32'hFFFF_FFFF);
    send_request(blil_pkg::OP_REMOVE, 32'h8000_0000);
    send_request(blil_pkg::OP_REMOVE, 32'h7FFF_FFFF);
    send_request(blil_pkg::OP_REMOVE, 32'h7FFF_FFFF);
    send_request(blil_pkg::OP_CLEAR,  32'hFFFF_FFFF);
    send_request(blil_pkg::OP_APPEND, 32'h0000_0001);
    send_request(blil_pkg::OP_APPEND, 32'h0000_0001);
    send_request(blil_pkg::OP_APPEND, 32'h0000_0002);
    send_request(blil_pkg::OP_REMOVE, 32'h0000_0001);
    send_request(blil_pkg::OP_REMOVE, 32'h0000_0002);
    send_request(blil_pkg::OP_REMOVE, 32'h0000_0001);
    send_request(blil_pkg::OP_REMOVE, 32'h0000_0001);
    wait_drained();

    // open with a long fill so the full list is reached early
    mode     = MODE_FILL;
    seg_left = 100;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        mode     = $urandom_range(MODE_MIXED);
        seg_left = $urandom_range(20, 90);
      end
      seg_left--;
      if (n == 300 || n == 900) wait_drained();
      if ((n < 500 || n >= 800) && $urandom_range(99) < 9)
        hold_off($urandom_range(1, 3));
      send_random(mode);
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
